// ----- rtl/core/cbps_pkg.sv -----
// Shared types and codes for the charger bus poll sequencer.
// No dependencies; imported by every module of the block.
package cbps_pkg;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DONE  = 2'd1,
    OP_SET   = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    DK_STATE = 3'd0,
    DK_POWER = 3'd1,
    DK_EON   = 3'd2,
    DK_ETOT  = 3'd3,
    DK_WRITE = 3'd4
  } done_kind_t;

  typedef enum logic [2:0] {
    REQ_NONE  = 3'd0,
    REQ_STATE = 3'd1,
    REQ_POWER = 3'd2,
    REQ_EON   = 3'd3,
    REQ_ETOT  = 3'd4,
    REQ_WRITE = 3'd5
  } req_kind_t;

  typedef enum logic [2:0] {
    CS_DISCONNECTED = 3'd0,
    CS_CONNECTED    = 3'd1,
    CS_CHARGING     = 3'd2,
    CS_DERATING     = 3'd3,
    CS_ERROR        = 3'd4
  } charge_state_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_STATE = 6'b000010,
    ST_POWER = 6'b000100,
    ST_EON   = 6'b001000,
    ST_ETOT  = 6'b010000,
    ST_WRITE = 6'b100000
  } step_t;

  localparam logic [2:0] CFG_POLL    = 3'd0;
  localparam logic [2:0] CFG_REFRESH = 3'd1;
  localparam logic [2:0] CFG_STUCK   = 3'd2;
  localparam logic [2:0] CFG_MIN     = 3'd3;
  localparam logic [2:0] CFG_MAX     = 3'd4;

  // raw charger state register codes
  localparam logic [15:0] RAW_DISC_A = 16'd2;
  localparam logic [15:0] RAW_DISC_B = 16'd3;
  localparam logic [15:0] RAW_CONN_A = 16'd4;
  localparam logic [15:0] RAW_CONN_B = 16'd5;
  localparam logic [15:0] RAW_CONN_C = 16'd6;
  localparam logic [15:0] RAW_CHARGE = 16'd7;
  localparam logic [15:0] RAW_DERATE = 16'd8;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  done_kind;
    logic        success;
    logic [31:0] value;
    logic [7:0]  amps;
  } item_t;

  typedef struct packed {
    logic [2:0]  request_kind;
    logic [11:0] request_value;
    logic        link_reset;
    logic [2:0]  charge_state;
    logic        link_online;
    logic [15:0] power_reading;
    logic [31:0] energy_since_on;
    logic [31:0] energy_lifetime;
    logic [7:0]  setpoint_out;
  } result_t;

  function automatic logic [2:0] map_state(input logic [15:0] raw);
    logic [2:0] cs;
    unique case (raw) inside
      RAW_DISC_A, RAW_DISC_B:             cs = CS_DISCONNECTED;
      RAW_CONN_A, RAW_CONN_B, RAW_CONN_C: cs = CS_CONNECTED;
      RAW_CHARGE:                         cs = CS_CHARGING;
      RAW_DERATE:                         cs = CS_DERATING;
      default:                            cs = CS_ERROR;
    endcase
    return cs;
  endfunction

endpackage

// ----- rtl/core/charger_bus_poll_sequencer_unit.sv -----
// Top level of the charger bus poll sequencer.
// Depends on cbps_pkg, cbps_in_stage, cbps_engine and cbps_out_stage.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   in      | in_valid / in_ready   | op, done_kind, success, value, amps
//   out     | out_valid / out_ready | request and status fields
//   cfg     | cfg_we                | cfg_index, cfg_wdata
//
// One transfer per cycle sustained while out_ready stays high; each item passes
// from input transfer to result transfer through the input register, then the
// result register, with the update logic between the two registers.
// Reset is synchronous, active low; configuration returns to its defaults.
// A stalled result holds the input register, which then drops in_ready.
module charger_bus_poll_sequencer_unit
  import cbps_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [2:0]           in_done_kind,
  input  logic                 in_success,
  input  logic [31:0]          in_value,
  input  logic [7:0]           in_amps,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_request_kind,
  output logic [11:0]          out_request_value,
  output logic                 out_link_reset,
  output logic [2:0]           out_charge_state,
  output logic                 out_link_online,
  output logic [15:0]          out_power_reading,
  output logic [31:0]          out_energy_since_on,
  output logic [31:0]          out_energy_lifetime,
  output logic [7:0]           out_setpoint_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  item_t   in_item, item;
  logic    item_valid, go;
  result_t result, out_result;

  assign in_item.op        = in_op;
  assign in_item.done_kind = in_done_kind;
  assign in_item.success   = in_success;
  assign in_item.value     = in_value;
  assign in_item.amps      = in_amps;

  cbps_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (go),
    .item_valid (item_valid),
    .item       (item)
  );

  cbps_engine #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .item      (item),
    .result    (result)
  );

  cbps_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .go         (go),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_request_kind    = out_result.request_kind;
  assign out_request_value   = out_result.request_value;
  assign out_link_reset      = out_result.link_reset;
  assign out_charge_state    = out_result.charge_state;
  assign out_link_online     = out_result.link_online;
  assign out_power_reading   = out_result.power_reading;
  assign out_energy_since_on = out_result.energy_since_on;
  assign out_energy_lifetime = out_result.energy_lifetime;
  assign out_setpoint_out    = out_result.setpoint_out;

endmodule

// ----- rtl/core/cbps_in_stage.sv -----
// Input register of the poll sequencer: holds one accepted transfer.
// Depends on cbps_pkg.
module cbps_in_stage
  import cbps_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || take;
  assign valid_nxt  = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/core/cbps_engine.sv -----
// Sequencer state, configuration registers and the per-item update logic.
// Depends on cbps_pkg.
module cbps_engine
  import cbps_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 go,
  input  item_t                item,
  output result_t              result
);

  localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

  logic [15:0] poll_r, refresh_r, stuck_r;
  logic [7:0]  min_r, max_r;

  step_t                 step_r, step_nxt;
  logic                  wdue_r, wdue_nxt;
  logic                  cwp_r, cwp_nxt;
  logic                  adv_r, adv_nxt;
  logic [TIME_WIDTH-1:0] spoll_r, spoll_nxt;
  logic [TIME_WIDTH-1:0] srefr_r, srefr_nxt;
  logic [TIME_WIDTH-1:0] ssucc_r, ssucc_nxt;
  logic [7:0]            setp_r, setp_nxt;
  logic [2:0]            cstate_r, cstate_nxt;
  logic                  online_r, online_nxt;
  logic [15:0]           power_r, power_nxt;
  logic [31:0]           eon_r, eon_nxt;
  logic [31:0]           etot_r, etot_nxt;

  logic [2:0]  req;
  logic        lreset;
  logic [11:0] setp_x10;

  function automatic logic [TIME_WIDTH-1:0] bump(input logic [TIME_WIDTH-1:0] t);
    return (t == {TIME_WIDTH{1'b1}}) ? t : t + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r    <= 16'd1000;
      refresh_r <= 16'd10000;
      stuck_r   <= 16'd10000;
      min_r     <= 8'd6;
      max_r     <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL:    poll_r    <= cfg_wdata;
        CFG_REFRESH: refresh_r <= cfg_wdata;
        CFG_STUCK:   stuck_r   <= cfg_wdata;
        CFG_MIN:     min_r     <= cfg_wdata[7:0];
        CFG_MAX:     max_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    step_nxt   = step_r;
    wdue_nxt   = wdue_r;
    cwp_nxt    = cwp_r;
    adv_nxt    = adv_r;
    spoll_nxt  = spoll_r;
    srefr_nxt  = srefr_r;
    ssucc_nxt  = ssucc_r;
    setp_nxt   = setp_r;
    cstate_nxt = cstate_r;
    online_nxt = online_r;
    power_nxt  = power_r;
    eon_nxt    = eon_r;
    etot_nxt   = etot_r;
    req        = REQ_NONE;
    lreset     = 1'b0;

    case (item.op)
      OP_TICK: begin
        spoll_nxt = bump(spoll_r);
        srefr_nxt = bump(srefr_r);
        ssucc_nxt = bump(ssucc_r);
        if (adv_r) begin
          adv_nxt = 1'b0;
          unique case (step_r)
            ST_STATE: begin step_nxt = ST_POWER; req = REQ_POWER; end
            ST_POWER: begin step_nxt = ST_EON;   req = REQ_EON;   end
            ST_EON:   begin step_nxt = ST_ETOT;  req = REQ_ETOT;  end
            ST_ETOT: begin
              if (wdue_r) begin
                step_nxt = ST_WRITE;
                cwp_nxt  = 1'b1;
                req      = REQ_WRITE;
              end else begin
                step_nxt = ST_IDLE;
              end
            end
            default: step_nxt = ST_IDLE;
          endcase
        end
        if (step_nxt == ST_IDLE &&
            CMP_W'(spoll_nxt) >= CMP_W'(poll_r)) begin
          spoll_nxt = '0;
          wdue_nxt  = CMP_W'(srefr_nxt) >= CMP_W'(refresh_r);
          if (wdue_nxt) begin
            srefr_nxt = '0;
          end
          step_nxt = ST_STATE;
          req      = REQ_STATE;
        end
        if (CMP_W'(ssucc_nxt) >= CMP_W'(stuck_r)) begin
          lreset    = 1'b1;
          req       = REQ_NONE;
          step_nxt  = ST_IDLE;
          cwp_nxt   = 1'b0;
          ssucc_nxt = '0;
        end
      end
      OP_DONE: begin
        if (item.done_kind <= DK_WRITE) begin
          if (item.success) begin
            ssucc_nxt = '0;
          end
          case (item.done_kind)
            DK_STATE: begin
              online_nxt = item.success;
              if (item.success) cstate_nxt = map_state(item.value[15:0]);
              adv_nxt = 1'b1;
            end
            DK_POWER: begin
              online_nxt = item.success;
              if (item.success) power_nxt = item.value[15:0];
              adv_nxt = 1'b1;
            end
            DK_EON: begin
              if (item.success) eon_nxt = item.value;
              adv_nxt = 1'b1;
            end
            DK_ETOT: begin
              if (item.success) etot_nxt = item.value;
              adv_nxt = 1'b1;
            end
            default: begin
              online_nxt = item.success;
              if (cwp_r) begin
                cwp_nxt = 1'b0;
                adv_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      OP_SET: begin
        if (item.amps < min_r) begin
          setp_nxt = min_r;
        end else if (item.amps > max_r) begin
          setp_nxt = max_r;
        end else begin
          setp_nxt = item.amps;
        end
        req = REQ_WRITE;
      end
      default: begin
        setp_nxt = 8'd0;
        req      = REQ_WRITE;
      end
    endcase
  end

  // times ten as 8x + 2x
  assign setp_x10 = {1'b0, setp_nxt, 3'b000} + {3'b000, setp_nxt, 1'b0};

  always_comb begin
    result.request_kind    = req;
    result.request_value   = (req == REQ_WRITE) ? setp_x10 : 12'd0;
    result.link_reset      = lreset;
    result.charge_state    = cstate_nxt;
    result.link_online     = online_nxt;
    result.power_reading   = power_nxt;
    result.energy_since_on = eon_nxt;
    result.energy_lifetime = etot_nxt;
    result.setpoint_out    = setp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= ST_IDLE;
      wdue_r   <= 1'b0;
      cwp_r    <= 1'b0;
      adv_r    <= 1'b0;
      spoll_r  <= '0;
      srefr_r  <= '0;
      ssucc_r  <= '0;
      setp_r   <= 8'd0;
      cstate_r <= CS_DISCONNECTED;
      online_r <= 1'b0;
      power_r  <= 16'd0;
      eon_r    <= 32'd0;
      etot_r   <= 32'd0;
    end else if (go) begin
      step_r   <= step_nxt;
      wdue_r   <= wdue_nxt;
      cwp_r    <= cwp_nxt;
      adv_r    <= adv_nxt;
      spoll_r  <= spoll_nxt;
      srefr_r  <= srefr_nxt;
      ssucc_r  <= ssucc_nxt;
      setp_r   <= setp_nxt;
      cstate_r <= cstate_nxt;
      online_r <= online_nxt;
      power_r  <= power_nxt;
      eon_r    <= eon_nxt;
      etot_r   <= etot_nxt;
    end
  end

endmodule

// ----- rtl/core/cbps_out_stage.sv -----
// Result register of the poll sequencer; loads while the previous result drains.
// Depends on cbps_pkg.
module cbps_out_stage
  import cbps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  result_t result,
  output logic    go,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign go         = item_valid && (!valid_r || out_ready);
  assign valid_nxt  = go ? 1'b1 : ((valid_r && out_ready) ? 1'b0 : valid_r);
  assign out_valid  = valid_r;
  assign out_result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= result;
    end
  end

endmodule

// ----- tb/charger_bus_poll_sequencer_unit_tb.sv -----
// Self-checking testbench for charger_bus_poll_sequencer_unit.
// Depends on cbps_pkg and the block's RTL; an internal predictor tracks the
// poll chain, timers and readings and checks every result transfer in order.
module charger_bus_poll_sequencer_unit_tb;
  import cbps_pkg::*;

  localparam int TW = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int WAIT_TICKS = 300;
  localparam logic [2:0] DK_UNUSED = 3'd5;
  localparam logic [2:0] DK_BAD = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic [2:0] in_done_kind = '0;
  logic in_success = 1'b0;
  logic [31:0] in_value = '0;
  logic [7:0] in_amps = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_request_kind;
  logic [11:0] out_request_value;
  logic out_link_reset;
  logic [2:0] out_charge_state;
  logic out_link_online;
  logic [15:0] out_power_reading;
  logic [31:0] out_energy_since_on;
  logic [31:0] out_energy_lifetime;
  logic [7:0] out_setpoint_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  charger_bus_poll_sequencer_unit #(.TIME_WIDTH(TW)) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_done_kind        (in_done_kind),
    .in_success          (in_success),
    .in_value            (in_value),
    .in_amps             (in_amps),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_request_kind    (out_request_kind),
    .out_request_value   (out_request_value),
    .out_link_reset      (out_link_reset),
    .out_charge_state    (out_charge_state),
    .out_link_online     (out_link_online),
    .out_power_reading   (out_power_reading),
    .out_energy_since_on (out_energy_since_on),
    .out_energy_lifetime (out_energy_lifetime),
    .out_setpoint_out    (out_setpoint_out),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #1 clk = ~clk;

  // predicted block state
  logic [15:0] m_poll, m_refresh, m_stuck;
  logic [7:0] m_min, m_max;
  step_t m_step;
  logic m_write_due, m_chain_wr, m_adv;
  logic [TW-1:0] m_since_poll, m_since_refresh, m_since_ok;
  logic [7:0] m_setpoint;
  charge_state_t m_cs;
  logic m_online;
  logic [15:0] m_power;
  logic [31:0] m_eon, m_etot;

  result_t replies_due[$];
  int err_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  logic steady = 1'b0;
  logic [7:0] rx_cnt = '0;
  int rx_stall = 0;

  function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  function automatic charge_state_t decode_raw(input logic [15:0] raw);
    case (raw)
      RAW_DISC_A, RAW_DISC_B: return CS_DISCONNECTED;
      RAW_CONN_A, RAW_CONN_B, RAW_CONN_C: return CS_CONNECTED;
      RAW_CHARGE: return CS_CHARGING;
      RAW_DERATE: return CS_DERATING;
      default: return CS_ERROR;
    endcase
  endfunction

  function automatic logic chain_waiting();
    return m_step != ST_IDLE && !m_adv;
  endfunction

  function automatic logic [2:0] awaited_kind();
    case (m_step)
      ST_STATE: return DK_STATE;
      ST_POWER: return DK_POWER;
      ST_EON: return DK_EON;
      ST_ETOT: return DK_ETOT;
      default: return DK_WRITE;
    endcase
  endfunction

  task automatic reset_model();
    m_poll = 16'd1000; m_refresh = 16'd10000; m_stuck = 16'd10000;
    m_min = 8'd6; m_max = 8'd16;
    m_step = ST_IDLE;
    m_write_due = 1'b0; m_chain_wr = 1'b0; m_adv = 1'b0;
    m_since_poll = '0; m_since_refresh = '0; m_since_ok = '0;
    m_setpoint = '0; m_cs = CS_DISCONNECTED; m_online = 1'b0;
    m_power = '0; m_eon = '0; m_etot = '0;
  endtask

  task automatic predict_poll_step(input item_t it, output result_t r);
    req_kind_t req;
    logic link_rst;
    req = REQ_NONE;
    link_rst = 1'b0;
    case (op_t'(it.op))
      OP_TICK: begin
        m_since_poll = sat_inc(m_since_poll);
        m_since_refresh = sat_inc(m_since_refresh);
        m_since_ok = sat_inc(m_since_ok);
        if (m_adv) begin
          m_adv = 1'b0;
          case (m_step)
            ST_STATE: begin m_step = ST_POWER; req = REQ_POWER; end
            ST_POWER: begin m_step = ST_EON; req = REQ_EON; end
            ST_EON: begin m_step = ST_ETOT; req = REQ_ETOT; end
            ST_ETOT: begin
              if (m_write_due) begin
                m_step = ST_WRITE;
                m_chain_wr = 1'b1;
                req = REQ_WRITE;
              end else begin
                m_step = ST_IDLE;
              end
            end
            default: m_step = ST_IDLE;
          endcase
        end
        if (m_step == ST_IDLE && m_since_poll >= m_poll) begin
          m_since_poll = '0;
          m_write_due = m_since_refresh >= m_refresh;
          if (m_write_due) m_since_refresh = '0;
          m_step = ST_STATE;
          req = REQ_STATE;
        end
        if (m_since_ok >= m_stuck) begin
          link_rst = 1'b1;
          req = REQ_NONE;
          m_step = ST_IDLE;
          m_chain_wr = 1'b0;
          m_since_ok = '0;
        end
      end
      OP_DONE: begin
        if (it.done_kind <= DK_WRITE) begin
          if (it.success) m_since_ok = '0;
          case (it.done_kind)
            DK_STATE: begin
              m_online = it.success;
              if (it.success) m_cs = decode_raw(it.value[15:0]);
              m_adv = 1'b1;
            end
            DK_POWER: begin
              m_online = it.success;
              if (it.success) m_power = it.value[15:0];
              m_adv = 1'b1;
            end
            DK_EON: begin
              if (it.success) m_eon = it.value;
              m_adv = 1'b1;
            end
            DK_ETOT: begin
              if (it.success) m_etot = it.value;
              m_adv = 1'b1;
            end
            default: begin
              m_online = it.success;
              if (m_chain_wr) begin
                m_chain_wr = 1'b0;
                m_adv = 1'b1;
              end
            end
          endcase
        end
      end
      OP_SET: begin
        if (it.amps < m_min) m_setpoint = m_min;
        else if (it.amps > m_max) m_setpoint = m_max;
        else m_setpoint = it.amps;
        req = REQ_WRITE;
      end
      default: begin
        m_setpoint = '0;
        req = REQ_WRITE;
      end
    endcase
    r.request_kind = req;
    r.request_value = (req == REQ_WRITE) ? 12'(m_setpoint) * 12'd10 : 12'd0;
    r.link_reset = link_rst;
    r.charge_state = m_cs;
    r.link_online = m_online;
    r.power_reading = m_power;
    r.energy_since_on = m_eon;
    r.energy_lifetime = m_etot;
    r.setpoint_out = m_setpoint;
  endtask

  function automatic item_t mk(input op_t op, input logic [2:0] kind, input logic ok,
                               input logic [31:0] v, input logic [7:0] a);
    item_t it;
    it.op = op;
    it.done_kind = kind;
    it.success = ok;
    it.value = v;
    it.amps = a;
    return it;
  endfunction

  function automatic item_t tick_item();
    return mk(OP_TICK, DK_STATE, 1'b0, 32'd0, 8'd0);
  endfunction

  function automatic item_t done_item(input logic [2:0] kind, input logic ok,
                                      input logic [31:0] v);
    return mk(OP_DONE, kind, ok, v, 8'd0);
  endfunction

  function automatic item_t set_item(input logic [7:0] a);
    return mk(OP_SET, DK_STATE, 1'b0, 32'd0, a);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it = mk(OP_TICK, 3'($urandom_range(0, 7)), $urandom_range(0, 9) != 0, $urandom,
            8'($urandom));
    if (chain_waiting() && pick < 45) begin
      it.op = OP_DONE;
      it.done_kind = awaited_kind();
      if (pick < 30) it.value[15:0] = 16'($urandom_range(0, 10));
    end else if (pick >= 80 && pick < 88) begin
      it.op = OP_DONE;
    end else if (pick >= 88 && pick < 96) begin
      it.op = OP_SET;
      if (pick < 91) it.amps = $urandom_range(0, 1) ? m_min : m_max;
    end else if (pick >= 96) begin
      it.op = OP_STOP;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    result_t r;
    if (!steady && burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else if (burst_left != 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_done_kind <= it.done_kind;
    in_success <= it.success;
    in_value <= it.value;
    in_amps <= it.amps;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_poll_step(it, r);
    replies_due.push_back(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] poll, input logic [15:0] refresh,
                            input logic [15:0] stuck, input logic [7:0] lo,
                            input logic [7:0] hi);
    logic [CFG_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0] idx [5];
    drain_results();
    repeat (3) @(posedge clk);
    vals = '{poll, refresh, stuck, 16'(lo), 16'(hi)};
    idx = '{CFG_POLL, CFG_REFRESH, CFG_STUCK, CFG_MIN, CFG_MAX};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_poll = poll; m_refresh = refresh; m_stuck = stuck;
    m_min = lo; m_max = hi;
  endtask

  task automatic walk_chain(input int n);
    for (int i = 0; i < n; i++) begin
      if (chain_waiting()) send_item(done_item(awaited_kind(), 1'b1, $urandom));
      else send_item(tick_item());
    end
  endtask

  task automatic test_reset_defaults();
    send_item(tick_item());
    send_item(tick_item());
    send_item(set_item(8'd3));
    send_item(set_item(8'd200));
    send_item(mk(OP_STOP, DK_STATE, 1'b0, 32'd0, 8'd0));
    send_item(done_item(DK_STATE, 1'b1, {16'hFFFF, RAW_CHARGE}));
    send_item(done_item(DK_POWER, 1'b0, 32'h0000_1234));
    send_item(done_item(DK_BAD, 1'b1, 32'hFFFF_FFFF));
  endtask

  task automatic test_chain_walk();
    set_config(16'd1, 16'd1, 16'd65535, 8'd6, 8'd16);
    send_item(tick_item());
    send_item(done_item(DK_STATE, 1'b1, {16'h0001, RAW_CHARGE}));
    send_item(tick_item());
    send_item(set_item(8'd12));
    send_item(done_item(DK_POWER, 1'b1, 32'hABCD_FFFF));
    send_item(tick_item());
    send_item(done_item(DK_EON, 1'b1, 32'hFFFF_FFFF));
    send_item(tick_item());
    send_item(done_item(DK_ETOT, 1'b1, 32'h8000_0000));
    send_item(tick_item());
    send_item(done_item(DK_WRITE, 1'b1, 32'd0));
    send_item(done_item(DK_STATE, 1'b0, {16'h0000, RAW_DERATE}));
    send_item(tick_item());
    send_item(done_item(DK_UNUSED, 1'b1, 32'd0));
    send_item(done_item(DK_STATE, 1'b1, {16'h0000, RAW_DISC_B}));
    send_item(done_item(DK_STATE, 1'b1, {16'h0000, RAW_CONN_C}));
    send_item(done_item(DK_STATE, 1'b1, 32'h0000_0009));
    send_item(done_item(DK_WRITE, 1'b1, 32'd0));
  endtask

  task automatic test_clamp_and_limits();
    // min above max, zero intervals, tight stuck timeout
    set_config(16'd0, 16'd0, 16'd3, 8'd200, 8'd100);
    send_item(set_item(8'd150));
    send_item(set_item(8'd255));
    send_item(set_item(8'd0));
    repeat (4) send_item(tick_item());
    set_config(16'd2, 16'd65535, 16'd0, 8'd0, 8'd255);
    send_item(tick_item());
    send_item(set_item(8'd0));
    send_item(set_item(8'd255));
    send_item(tick_item());
    set_config(16'd1, 16'd1, 16'd65535, 8'd0, 8'd0);
    send_item(set_item(8'd255));
    send_item(mk(OP_STOP, DK_STATE, 1'b0, 32'd0, 8'd0));
  endtask

  task automatic test_long_wait();
    steady = 1'b1;
    set_config(16'd1, 16'd65535, 16'd65535, 8'd6, 8'd16);
    while (!(m_step == ST_STATE && !m_adv)) walk_chain(1);
    set_config(16'd65535, 16'd65535, 16'd65535, 8'd6, 8'd16);
    for (int n = 0; n < WAIT_TICKS; n++) begin
      if (n % 40 == 39) send_item(done_item(DK_WRITE, 1'b1, 32'd0));
      else send_item(tick_item());
    end
    walk_chain(14);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(16'd1, 16'd65535, 16'd65535, 8'd0, 8'd255);
        1: set_config(16'd0, 16'd0, 16'd65535, 8'd255, 8'd0);
        2: set_config(16'd65535, 16'd1, 16'd1, 8'd6, 8'd16);
        default: set_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 40)),
                            16'($urandom_range(6, 90)), 8'($urandom), 8'($urandom));
      endcase
      for (int i = 0; i < 100; i++) send_item(random_item());
    end
  endtask

  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 1'b1;
    if (steady) begin
      out_ready <= 1'b1;
    end else if (rx_stall != 0) begin
      out_ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (rx_cnt[7]) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 31) == 0) rx_stall <= $urandom_range(2, 12);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("charger_bus_poll_sequencer_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.request_kind = out_request_kind;
      got.request_value = out_request_value;
      got.link_reset = out_link_reset;
      got.charge_state = out_charge_state;
      got.link_online = out_link_online;
      got.power_reading = out_power_reading;
      got.energy_since_on = out_energy_since_on;
      got.energy_lifetime = out_energy_lifetime;
      got.setpoint_out = out_setpoint_out;
      if (replies_due.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("cycle %0d: unexpected transfer, request kind %0d", cycle_count,
                   got.request_kind);
      end else begin
        want = replies_due.pop_front();
        if (got.request_kind !== want.request_kind ||
            got.request_value !== want.request_value ||
            got.link_reset !== want.link_reset ||
            got.charge_state !== want.charge_state ||
            got.link_online !== want.link_online ||
            got.power_reading !== want.power_reading ||
            got.energy_since_on !== want.energy_since_on ||
            got.energy_lifetime !== want.energy_lifetime ||
            got.setpoint_out !== want.setpoint_out) begin
          err_count++;
          if (err_count <= 10) begin
            $display("cycle %0d mismatch (exp/got): kind %0d/%0d value %0d/%0d reset %b/%b",
                     cycle_count, want.request_kind, got.request_kind, want.request_value,
                     got.request_value, want.link_reset, got.link_reset);
            $display("  state %0d/%0d online %b/%b power %h/%h eon %h/%h etot %h/%h amps %0d/%0d",
                     want.charge_state, got.charge_state, want.link_online, got.link_online,
                     want.power_reading, got.power_reading, want.energy_since_on,
                     got.energy_since_on, want.energy_lifetime, got.energy_lifetime,
                     want.setpoint_out, got.setpoint_out);
          end
        end
      end
    end
  end

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_chain_walk();
    test_clamp_and_limits();
    test_long_wait();
    test_random_traffic();
    drain_results();
    repeat (4) @(posedge clk);
    if (err_count == 0 && replies_due.size() == 0) begin
      $display("charger_bus_poll_sequencer_unit verification clean");
    end else begin
      $display("charger_bus_poll_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
